// ===== rtl/pcm_sample_format_converter_assert.svh =====
// Assertion macros shared by the converter's checker.
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH

// Same-cycle implication, ignored while reset is active
`define PSFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psfc check failed");

// Next-cycle implication, ignored while reset is active
`define PSFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psfc check failed");

`endif

// ===== rtl/psfc_pkg.sv =====
`default_nettype none

package psfc_pkg;

  // Target sample format, held in the configuration register
  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_S32 = 2'd2,
    FMT_FLT = 2'd3
  } fmt_e;

  // Source sample format carried with each item
  typedef enum logic [2:0] {
    KIND_UNDEF = 3'd0,
    KIND_S8    = 3'd1,
    KIND_S16   = 3'd2,
    KIND_S24   = 3'd3,
    KIND_S32   = 3'd4,
    KIND_FLT   = 3'd5,
    KIND_DSD   = 3'd6
  } kind_e;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] sample_in;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        status;
    logic        last_out;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/pcm_sample_format_converter.sv =====
`default_nettype none

// PCM sample format converter. One sample enters per transaction on the input
// channel and exactly one converted sample leaves, in order, on the output
// channel. The target format comes from the configuration register (reset:
// s24 in 32); write it only while no sample is in flight. The block is a
// two-register pipeline: an input register and a result register with the
// whole conversion (sign extension, shifts, float decode with truncate and
// clamp, integer-to-float normalize with round-to-nearest-even) between them.
// The accepted sample is held in the input register and its result in the
// result register, which drives the output channel.
// A new sample can be taken every cycle; throughput drops only while the
// output side stalls.
module pcm_sample_format_converter (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire psfc_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output psfc_pkg::out_item_t      out_item_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [1:0]               cfg_data_i
);
  import psfc_pkg::*;

  fmt_e      fmt_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      out_load;
  logic      s1_load;
  out_item_t res_d;

  // Handshake: result register frees when empty or taken
  assign out_load    = !out_valid_q || !out_stall_i;
  assign s1_load     = !s1_valid_q || out_load;
  assign in_stall_o  = !s1_load;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_S24;
    end else if (cfg_valid_i) begin
      fmt_q <= fmt_e'(cfg_data_i);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (out_load && s1_valid_q) begin
      out_item_q <= res_d;
    end
  end

  // Float to signed integer: truncate toward zero, clamp to 2^(n)-1 / -2^n,
  // NaN gives zero. n is log2 of the scale and also the magnitude bits.
  function automatic logic [31:0] flt_to_int(input logic [31:0] f,
                                             input logic [4:0]  n);
    logic        neg;
    logic [7:0]  e;
    logic [9:0]  ex;
    logic [23:0] mag;
    logic [23:0] sval;
    logic [23:0] lim;
    neg = f[31];
    e   = f[30:23];
    ex  = {2'b00, e} - 10'd127 + {5'd0, n};
    lim = 24'd1 << n;
    if (e == 8'hFF && f[22:0] != 23'd0) begin
      sval = 24'd0;
    end else if (ex[9]) begin
      sval = 24'd0;
    end else if (ex >= {5'd0, n}) begin
      sval = neg ? (24'd0 - lim) : (lim - 24'd1);
    end else begin
      mag  = {1'b1, f[22:0]} >> (5'd23 - ex[4:0]);
      sval = neg ? (24'd0 - mag) : mag;
    end
    return {{8{sval[23]}}, sval};
  endfunction

  // Signed integer to float, scaled by 2^-(bits-1), round to nearest even
  function automatic logic [31:0] int_to_flt(input logic [31:0] v,
                                             input logic [5:0]  bits);
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [7:0]  ex;
    logic        rnd;
    logic [30:0] body;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    p   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        p = 5'(i);
      end
    end
    norm = mag << (5'd31 - p);
    ex   = 8'(p) + 8'd128 - 8'(bits);
    rnd  = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
    body = {ex, norm[30:8]} + {30'd0, rnd};
    if (mag == 32'd0) begin
      return 32'd0;
    end
    return {neg, body};
  endfunction

  // Conversion between the two registers
  always_comb begin
    logic [31:0] raw;
    logic [31:0] v;
    logic [5:0]  bits;
    logic        bad;
    logic [31:0] res;
    logic [31:0] f24;
    raw  = s1_item_q.sample_in;
    bad  = 1'b0;
    res  = 32'd0;
    v    = raw;
    bits = 6'd32;
    case (s1_item_q.kind)
      KIND_S8: begin
        v    = {{24{raw[7]}}, raw[7:0]};
        bits = 6'd8;
      end
      KIND_S16: begin
        v    = {{16{raw[15]}}, raw[15:0]};
        bits = 6'd16;
      end
      KIND_S24: begin
        v    = {{8{raw[23]}}, raw[23:0]};
        bits = 6'd24;
      end
      KIND_S32, KIND_FLT: begin
        v    = raw;
        bits = 6'd32;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    f24 = flt_to_int(raw, 5'd23);
    if (!bad && s1_item_q.kind == KIND_FLT) begin
      case (fmt_q)
        FMT_S16: res = flt_to_int(raw, 5'd15);
        FMT_S24: res = f24;
        FMT_S32: res = {f24[23:0], 8'd0};
        default: res = raw;
      endcase
    end else if (!bad) begin
      case (fmt_q)
        FMT_S16: begin
          if (bits == 6'd8) begin
            res = {v[23:0], 8'd0};
          end else if (bits == 6'd16) begin
            res = v;
          end else begin
            bad = 1'b1;
          end
        end
        FMT_S24: begin
          if (bits == 6'd32) begin
            res = {{8{v[31]}}, v[31:8]};
          end else begin
            res = v << (6'd24 - bits);
          end
        end
        FMT_S32: res = v << (6'd32 - bits);
        default: res = int_to_flt(v, bits);
      endcase
    end

    res_d.sample_out = bad ? 32'd0 : res;
    res_d.status     = bad ? STATUS_UNSUPPORTED : STATUS_OK;
    res_d.last_out   = s1_item_q.last_in;
  end

endmodule

`default_nettype wire

// ===== rtl/psfc_checker.sv =====
`default_nettype none

`include "pcm_sample_format_converter_assert.svh"

// Port-level checks for the sample format converter
module psfc_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_stall_o,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire psfc_pkg::out_item_t out_item_o
);
  import psfc_pkg::*;

  // A stalled result holds
  `PSFC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // Unsupported transactions carry a zero sample
  `PSFC_ASSERT_NOW(a_bad_zero, out_valid_o && out_item_o.status == STATUS_UNSUPPORTED, out_item_o.sample_out == 32'd0)

  // With the result register empty the input never stalls
  `PSFC_ASSERT_NOW(a_no_stall, !out_valid_o, !in_stall_o)

  // A new result follows an accepted transaction through the input register
  `PSFC_ASSERT_NOW(a_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

endmodule

bind pcm_sample_format_converter psfc_checker u_psfc_checker (.*);

`default_nettype wire

// ===== sim/pcm_sample_format_converter_check.sv =====
`timescale 1ns / 100ps

// Watches the converter's channels, predicts every converted sample and
// compares it with what leaves the output channel.
module pcm_sample_format_converter_check (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  psfc_pkg::in_item_t  in_item_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  psfc_pkg::out_item_t out_item_i,
  input  wire                 cfg_valid_i,
  input  wire                 cfg_ready_i,
  input  wire  [1:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import psfc_pkg::*;

  fmt_e      target_q;
  out_item_t sample_fifo[$];

  // Float times 2^scale_bits, truncated toward zero, clamped to int_width bits
  function automatic logic [31:0] float_to_int(logic [31:0] f, int scale_bits, int int_width);
    int          e;
    int          sh;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] lim;
    e   = f[30:23];
    lim = 64'd1 << (int_width - 1);
    if (e == 255) begin
      if (f[22:0] != 0) return 32'd0;
      mag = lim;
    end else if (e == 0) begin
      mag = 0;
    end else if (e - 127 + scale_bits >= 40) begin
      mag = lim;
    end else begin
      m  = {40'd0, 1'b1, f[22:0]};
      sh = e - 150 + scale_bits;
      if (sh >= 0) mag = m << sh;
      else if (-sh >= 24) mag = 0;
      else mag = m >> (-sh);
    end
    if (!f[31]) begin
      if (mag >= lim - 1) return 32'(lim - 1);
      return 32'(mag);
    end
    if (mag >= lim) return 32'(-lim);
    return 32'(-mag);
  endfunction

  // Integer times 2^-frac_bits as single float, round to nearest even
  function automatic logic [31:0] int_to_float(logic [31:0] v, int frac_bits);
    logic        s;
    logic [32:0] mag;
    logic [32:0] mant;
    logic [32:0] rem;
    logic [32:0] half;
    logic [7:0]  ex;
    int          p;
    int          sh;
    if (v == 0) return 32'd0;
    s   = v[31];
    mag = s ? (33'd0 - {1'b1, v}) : {1'b0, v};
    p   = 0;
    for (int i = 0; i < 33; i++) if (mag[i]) p = i;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      sh   = p - 23;
      mant = mag >> sh;
      rem  = mag & ((33'd1 << sh) - 33'd1);
      half = 33'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 33'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    ex = 8'(p + 127 - frac_bits);
    return {s, ex, mant[22:0]};
  endfunction

  function automatic out_item_t convert_sample(fmt_e fmt, in_item_t it);
    out_item_t   r;
    int          bits;
    logic [31:0] v;
    logic        bad;
    bad  = 1'b0;
    r    = '0;
    bits = 0;
    v    = 32'd0;
    case (it.kind)
      KIND_S8:  bits = 8;
      KIND_S16: bits = 16;
      KIND_S24: bits = 24;
      KIND_S32: bits = 32;
      default:  bits = 0;
    endcase
    if (it.kind == KIND_FLT) begin
      case (fmt)
        FMT_S16: r.sample_out = float_to_int(it.sample_in, 15, 16);
        FMT_S24: r.sample_out = float_to_int(it.sample_in, 23, 24);
        FMT_S32: r.sample_out = float_to_int(it.sample_in, 23, 24) << 8;
        default: r.sample_out = it.sample_in;
      endcase
    end else if (bits == 0) begin
      bad = 1'b1;
    end else begin
      // sign-extend the kind's low bits
      v = (it.sample_in << (32 - bits));
      v = $signed(v) >>> (32 - bits);
      case (fmt)
        FMT_S16: begin
          if (bits == 8) r.sample_out = v << 8;
          else if (bits == 16) r.sample_out = v;
          else bad = 1'b1;
        end
        FMT_S24: begin
          if (bits == 32) r.sample_out = $signed(v) >>> 8;
          else r.sample_out = v << (24 - bits);
        end
        FMT_S32: r.sample_out = v << (32 - bits);
        default: r.sample_out = int_to_float(v, bits - 1);
      endcase
    end
    if (bad) r.sample_out = 32'd0;
    r.status   = bad ? STATUS_UNSUPPORTED : STATUS_OK;
    r.last_out = it.last_in;
    return r;
  endfunction

  assign pending_o = sample_fifo.size();

  // Output check first, then prediction of the newly accepted input
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      target_q     <= FMT_S24;
      fail_count_o <= 0;
      checked_o    <= 0;
      sample_fifo.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (sample_fifo.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("mismatch: unexpected result %h", out_item_i);
        end else begin
          want = sample_fifo.pop_front();
          if (want.sample_out !== out_item_i.sample_out || want.status !== out_item_i.status
              || want.last_out !== out_item_i.last_out) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: sample exp %h got %h, status exp %b got %b, last exp %b got %b",
                       want.sample_out, out_item_i.sample_out, want.status,
                       out_item_i.status, want.last_out, out_item_i.last_out);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        sample_fifo.push_back(convert_sample(target_q, in_item_i));
      if (cfg_valid_i && cfg_ready_i)
        target_q <= fmt_e'(cfg_data_i);
    end
  end
endmodule

// ===== sim/pcm_sample_format_converter_test.sv =====
`timescale 1ns / 100ps

module pcm_sample_format_converter_test;
  import psfc_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_data;
  int        fail_count;
  int        pending;
  int        checked;
  int        sent;
  bit        quiet;

  pcm_sample_format_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  pcm_sample_format_converter_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver backpressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall = !quiet && ($urandom_range(0, 99) < 23);
    end
  end

  // One input transaction, with random idle cycles ahead of it
  task automatic send_sample(logic [2:0] kind, logic [31:0] smp, logic last);
    while (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid          = 1'b1;
    in_item.kind      = kind;
    in_item.sample_in = smp;
    in_item.last_in   = last;
    do @(posedge clk_i); while (in_stall);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_target(fmt_e fmt);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = fmt;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] edges[11];
    edges = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00800000,
              32'hFF7FFFFF, 32'h8000, 32'h7FFF, 32'h80, 32'h7F};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return edges[$urandom_range(0, 10)];
      2: return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
      default: return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'($urandom) : 23'd0)};
    endcase
  endfunction

  initial begin
    logic [2:0]  dir_kind[24];
    logic [31:0] dir_smp[24];
    fmt_e        dir_fmt[4];
    fmt_e        rnd_fmt[8];
    logic [2:0]  k;
    int          errs;

    dir_kind = '{KIND_S8, KIND_S8, KIND_S16, KIND_S24, KIND_S32, KIND_S32,
                 KIND_FLT, KIND_FLT, KIND_FLT, KIND_FLT, KIND_FLT, KIND_FLT,
                 KIND_FLT, KIND_FLT, KIND_UNDEF, KIND_DSD, 3'd7, KIND_S24,
                 KIND_S16, KIND_FLT, KIND_S32, KIND_S32, KIND_FLT, KIND_S32};
    dir_smp  = '{32'h80, 32'hFFFFFF7F, 32'h8000, 32'h800000, 32'h80000000, 32'h7FFFFFFF,
                 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h3F800000, 32'hBF800000,
                 32'h3F000000, 32'h00000001, 32'h80000000, 32'h12345678, 32'hFFFFFFFF,
                 32'h5A5A5A5A, 32'hAB7FFFFF, 32'hFFFF7FFF, 32'h3F7FFFFF, 32'h00FFFFFF,
                 32'h01000001, 32'hC7000000, 32'hFFFFFFFF};
    dir_fmt  = '{FMT_S24, FMT_S16, FMT_S32, FMT_FLT};
    rnd_fmt  = '{FMT_S16, FMT_FLT, FMT_S32, FMT_S24, FMT_S16, FMT_FLT, FMT_S32, FMT_S24};

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    quiet     = 1'b0;
    sent      = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corner samples, first under the reset target
    foreach (dir_fmt[f]) begin
      if (f != 0) write_target(dir_fmt[f]);
      for (int i = 0; i < 6; i++)
        send_sample(dir_kind[f * 6 + i], dir_smp[f * 6 + i], i[0]);
    end

    // Random phases over every target format
    foreach (rnd_fmt[p]) begin
      write_target(rnd_fmt[p]);
      quiet = (p == 4);
      for (int i = 0; i < 181; i++) begin
        k = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 5))
                                         : 3'($urandom_range(0, 7));
        send_sample(k, pick_sample(), $urandom_range(0, 7) == 0);
      end
      quiet = 1'b0;
    end

    drain();
    repeat (8) @(negedge clk_i);
    errs = fail_count + pending;
    $display("Sent %0d samples over all source kinds, %0d results checked, %0d mismatches.",
             sent, checked, errs);
    $display("Every target format was set, with idle and stall gaps on both sides.");
    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
